/* design/byte_translate_delete_squeeze_top_defines.svh */
// Assertion macros used by the byte filter top level.
`ifndef BYTE_TRANSLATE_DELETE_SQUEEZE_TOP_DEFINES_SVH
`define BYTE_TRANSLATE_DELETE_SQUEEZE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BTS_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("bts: assertion failed");
`define BTS_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bts: implication failed");
`else
`define BTS_ASSERT(name, clk, rstn, prop)
`define BTS_ASSERT_IMPL(name, clk, rstn, ante, cons)
`endif
`endif

/* design/bts_pkg.sv */
// Types and constants shared by the byte filter modules.
package bts_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int TABLE_D   = 1 << BYTE_W;

    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELETE_ENABLE  = 1'b0,
        REG_SQUEEZE_ENABLE = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_DATA,
        KIND_WRITE
    } item_kind_t;

    typedef struct packed {
        item_kind_t kind;
        byte_t      addr;
        byte_t      mapped;
        logic       del_mark;
        logic       sq_mark;
    } queue_item_t;

    typedef struct packed {
        logic        valid;
        queue_item_t item;
    } queue_head_t;

    typedef struct packed {
        logic delete_enable;
        logic squeeze_enable;
    } filter_cfg_t;

endpackage

/* design/bts_in_if.sv */
// Input request channel: data bytes and table writes.
interface bts_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [bts_pkg::BYTE_W-1:0]  data_byte;
    logic [bts_pkg::BYTE_W-1:0]  entry_index;
    logic [bts_pkg::BYTE_W-1:0]  mapped_byte;
    logic                        delete_mark;
    logic                        squeeze_mark;

    modport source (
        output valid, mode, data_byte, entry_index, mapped_byte, delete_mark, squeeze_mark,
        input  ready
    );
    modport sink (
        input  valid, mode, data_byte, entry_index, mapped_byte, delete_mark, squeeze_mark,
        output ready
    );
endinterface

/* design/bts_out_if.sv */
// Output request channel: filtered bytes.
interface bts_out_if;
    logic                        valid;
    logic                        ready;
    logic [bts_pkg::BYTE_W-1:0]  out_byte;

    modport source (
        output valid, out_byte,
        input  ready
    );
    modport sink (
        input  valid, out_byte,
        output ready
    );
endinterface

/* design/bts_cfg_if.sv */
// Configuration write channel.
interface bts_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bts_pkg::CFG_IDX_W-1:0]  index;
    logic                           data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* design/bts_front.sv */
// Front end: accept and classify requests into a short queue.
module bts_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bts_in_if.sink                               in_ch,
    input  logic                                 pop,
    output bts_pkg::queue_head_t                 head,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     count
);
    import bts_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_item_t       q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    queue_item_t       in_item;
    logic              push;
    logic              pop_ok;

    // Table writes address by entry_index, data bytes by the byte itself.
    always_comb
    begin
        in_item.kind     = (in_ch.mode == MODE_WRITE) ? KIND_WRITE : KIND_DATA;
        in_item.addr     = (in_ch.mode == MODE_WRITE) ? in_ch.entry_index : in_ch.data_byte;
        in_item.mapped   = in_ch.mapped_byte;
        in_item.del_mark = in_ch.delete_mark;
        in_item.sq_mark  = in_ch.squeeze_mark;
    end

    assign in_ch.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign pop_ok      = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem[rd_ptr_reg];
    assign count      = count_reg;

endmodule

/* design/bts_back.sv */
// Back end: table lookups, delete and squeeze decision, output register.
module bts_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bts_pkg::queue_head_t  head,
    input  bts_pkg::filter_cfg_t  cfg,
    output logic                  pop,
    bts_out_if.source             out_ch
);
    import bts_pkg::*;

    typedef struct packed {
        byte_t mapped;
        logic  del_mark;
    } xlat_entry_t;

    // Translation and delete mark, read by input byte.
    xlat_entry_t        xlat_mem [TABLE_D];
    // Squeeze mark, read by translated byte.
    logic               sq_mem [TABLE_D];
    // Rows written since reset; an unwritten row reads as identity, no marks.
    logic [TABLE_D-1:0] written_reg;

    logic               adv;

    logic               s1_valid_reg;
    queue_item_t        s1_item_reg;
    xlat_entry_t        xlat_rd_reg;
    logic               s1_hit_reg;
    byte_t              s1_xlat;
    logic               s1_del;

    logic               s2_valid_reg;
    item_kind_t         s2_kind_reg;
    byte_t              s2_xlat_reg;
    logic               s2_del_reg;
    logic               s2_hit_reg;
    logic               sq_rd_reg;

    logic               deleted;
    logic               squeezed;
    logic               emit;

    logic               out_valid_reg;
    byte_t              out_byte_reg;
    byte_t              prev_reg;
    logic               prev_valid_reg;

    // Advance the whole pipe unless the output register is stuck.
    assign adv = !out_valid_reg || out_ch.ready;
    assign pop = head.valid && adv;

    // Stage 1: read translation by input byte, write the row on a table request.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            xlat_rd_reg <= xlat_mem[head.item.addr];
            s1_hit_reg  <= written_reg[head.item.addr];
            s1_item_reg <= head.item;
            if (head.item.kind == KIND_WRITE)
            begin
                xlat_mem[head.item.addr] <= '{mapped: head.item.mapped,
                                              del_mark: head.item.del_mark};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (pop && (head.item.kind == KIND_WRITE))
        begin
            written_reg[head.item.addr] <= 1'b1;
        end
    end

    assign s1_xlat = s1_hit_reg ? xlat_rd_reg.mapped : s1_item_reg.addr;
    assign s1_del  = s1_hit_reg & xlat_rd_reg.del_mark;

    // Stage 2: read squeeze mark by translated byte.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rd_reg   <= sq_mem[s1_xlat];
            s2_hit_reg  <= written_reg[s1_xlat];
            s2_kind_reg <= s1_item_reg.kind;
            s2_xlat_reg <= s1_xlat;
            s2_del_reg  <= s1_del;
            if (s1_valid_reg && (s1_item_reg.kind == KIND_WRITE))
            begin
                sq_mem[s1_item_reg.addr] <= s1_item_reg.sq_mark;
            end
        end
    end

    always_comb
    begin
        deleted  = cfg.delete_enable & s2_del_reg;
        squeezed = cfg.squeeze_enable & s2_hit_reg & sq_rd_reg & prev_valid_reg
                   & (prev_reg == s2_xlat_reg);
        emit     = s2_valid_reg && (s2_kind_reg == KIND_DATA) && !deleted && !squeezed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= head.valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= emit;
            if (emit)
            begin
                prev_reg       <= s2_xlat_reg;
                prev_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            out_byte_reg <= s2_xlat_reg;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;

endmodule

/* design/byte_translate_delete_squeeze_top.sv */
// Top level of the streaming byte translate, delete and squeeze filter.
//
// Channels: in_ch carries requests, either a data byte (mode 0) or a table
// write (mode 1) that sets the translation, delete mark and squeeze mark of
// one index. out_ch carries the bytes kept in the stream, zero or one per
// data byte. cfg_ch writes delete_enable (index 0) and squeeze_enable
// (index 1); it is always ready. The user must write it only while the block
// is idle; the block does not enforce this. A data byte passes the queue,
// stage 1, stage 2 and the output register to out_ch. Throughput: one request
// per cycle unless out_ch stalls, set by the single read port of each table,
// one lookup per pipeline stage. A table write takes effect for the very
// next request. Reset clears the enables, the last emitted byte and the row
// written flags, so every table row reads as identity with no marks; no
// clearing pass. When out_ch stalls, the pipeline holds and the front queue
// keeps taking requests until it fills, then in_ch.ready drops.
`include "byte_translate_delete_squeeze_top_defines.svh"
module byte_translate_delete_squeeze_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    bts_in_if.sink     in_ch,
    bts_out_if.source  out_ch,
    bts_cfg_if.sink    cfg_ch
);
    import bts_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    filter_cfg_t       cfg_reg;
    queue_head_t       head;
    logic              pop;
    logic [CNT_W-1:0]  count;
    logic              push;

    assign cfg_ch.ready = 1'b1;
    assign push         = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_reg_t'(cfg_ch.index))
                REG_DELETE_ENABLE:  cfg_reg.delete_enable  <= cfg_ch.data;
                REG_SQUEEZE_ENABLE: cfg_reg.squeeze_enable <= cfg_ch.data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    bts_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .pop   (pop),
        .head  (head),
        .count (count)
    );

    bts_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .cfg    (cfg_reg),
        .pop    (pop),
        .out_ch (out_ch)
    );

    `BTS_ASSERT(a_queue_bound, clk, rst_n, count <= CNT_W'(QUEUE_DEPTH))
    `BTS_ASSERT(a_push_fills, clk, rst_n, (push && !pop) |=> (count == $past(count) + 1'b1))
    `BTS_ASSERT_IMPL(a_pop_has_item, clk, rst_n, pop, count != '0)

endmodule
